@@ rtl/rgb_to_hsi_pixel_converter_top_macros.svh @@
// Assertion helpers used by the converter top module.
`ifndef RGB_TO_HSI_PIXEL_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_HSI_PIXEL_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset
`define RHPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during reset
`define RHPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rhpc_pkg.sv @@
`default_nettype none
package rhpc_pkg;

  // Hue fraction bits and the row length (one quotient bit per cell)
  localparam int FRAC_BITS = 16;
  localparam int CELLS     = FRAC_BITS + 1;
  localparam int P_W       = FRAC_BITS - 1;

  // Hue divider operand width (max(|2R-G-B|*2^20, |G-B|*sqrt3*2^20))
  localparam int HD_W   = 29;
  // Saturation divider: denominator 2*sum, numerator 510*(sum-3min)+sum
  localparam int SD_W   = 11;
  localparam int SNUM_W = 19;

  localparam logic [20:0] SQRT3_Q20  = 21'd1816187;
  localparam logic [15:0] ATAN_K_Q20 = 16'd45560;
  localparam logic [13:0] RECIP6_Q16 = 14'd10923;

  // Beat moving down the cell row
  typedef struct packed {
    logic              valid;
    logic [HD_W-1:0]   hrem;
    logic [HD_W-1:0]   hden;
    logic [CELLS-1:0]  hbits;
    logic [CELLS-1:0]  hq;
    logic [SD_W-1:0]   srem;
    logic [SD_W-1:0]   sden;
    logic [CELLS-1:0]  sbits;
    logic [CELLS-1:0]  sq;
    logic              steep;
    logic              xneg;
    logic              yneg;
    logic              grey;
    logic [7:0]        inten;
  } cell_t;

  // Finished result out of the tail
  typedef struct packed {
    logic       valid;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] inten;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/rhpc_px_if.sv @@
`default_nettype none
interface rhpc_px_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

@@ rtl/rhpc_hsi_if.sv @@
`default_nettype none
interface rhpc_hsi_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] intensity;

  modport source (output valid, output hue, output saturation, output intensity, input ready);
  modport sink   (input valid, input hue, input saturation, input intensity, output ready);
endinterface
`default_nettype wire

@@ rtl/rgb_to_hsi_pixel_converter_top.sv @@
// Channel   Dir  Payload                           Handshake
// in_px     in   red, green, blue (8b each)        valid/ready
// out_hsi   out  hue, saturation, intensity (8b)   valid/ready
//
// One pixel per clock sustained while the skid register is empty.
// The division cell row yields one quotient bit per cell.
// Synchronous active-low reset clears only the valid bits and the skid flag.
// A stalled output holds one result plus one in the skid register; ready
// drops only while the skid register is full.
`default_nettype none
`include "rgb_to_hsi_pixel_converter_top_macros.svh"
module rgb_to_hsi_pixel_converter_top (
  input  wire              clk,
  input  wire              rst_n,
  rhpc_px_if.sink          in_px,
  rhpc_hsi_if.source       out_hsi
);

  rhpc_pkg::cell_t chain [rhpc_pkg::CELLS+1];
  rhpc_pkg::res_t  res;
  logic            en;

  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_hue_r, out_hue_nxt;
  logic [7:0]      out_sat_r, out_sat_nxt;
  logic [7:0]      out_int_r, out_int_nxt;
  logic            skid_full_r, skid_full_nxt;
  rhpc_pkg::res_t  skid_r, skid_nxt;

  // pipeline runs whenever the skid register has room
  assign en          = !skid_full_r;
  assign in_px.ready = en;

  rhpc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .valid (in_px.valid),
    .red   (in_px.red),
    .green (in_px.green),
    .blue  (in_px.blue),
    .cout  (chain[0])
  );

  for (genvar i = 0; i < rhpc_pkg::CELLS; i++) begin : g_cell
    rhpc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .cin   (chain[i]),
      .cout  (chain[i+1])
    );
  end

  rhpc_tail u_tail (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cin   (chain[rhpc_pkg::CELLS]),
    .res   (res)
  );

  // output register with one-beat skid
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_hue_nxt   = out_hue_r;
    out_sat_nxt   = out_sat_r;
    out_int_nxt   = out_int_r;
    skid_full_nxt = skid_full_r;
    skid_nxt      = skid_r;
    if (!out_valid_r || out_hsi.ready) begin
      if (skid_full_r) begin
        out_valid_nxt = 1'b1;
        out_hue_nxt   = skid_r.hue;
        out_sat_nxt   = skid_r.sat;
        out_int_nxt   = skid_r.inten;
        skid_full_nxt = 1'b0;
      end else begin
        out_valid_nxt = res.valid;
        out_hue_nxt   = res.hue;
        out_sat_nxt   = res.sat;
        out_int_nxt   = res.inten;
      end
    end else if (res.valid && en) begin
      skid_full_nxt = 1'b1;
      skid_nxt      = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hue_r <= out_hue_nxt;
    out_sat_r <= out_sat_nxt;
    out_int_r <= out_int_nxt;
    skid_r    <= skid_nxt;
  end

  assign out_hsi.valid      = out_valid_r;
  assign out_hsi.hue        = out_hue_r;
  assign out_hsi.saturation = out_sat_r;
  assign out_hsi.intensity  = out_int_r;

  `RHPC_ASSERT_IMP(a_skid_has_out, skid_full_r, out_valid_r, "skid full with empty output")
  `RHPC_ASSERT_NXT(a_skid_drain, skid_full_r && out_hsi.ready, out_valid_r && !skid_full_r, "skid did not drain")
  `RHPC_ASSERT_NXT(a_stall_fill, res.valid && en && out_valid_r && !out_hsi.ready, skid_full_r, "stalled result lost")

endmodule
`default_nettype wire

@@ rtl/rhpc_cell.sv @@
`default_nettype none
// One restoring-division step for both the hue ratio and the saturation quotient
module rhpc_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  rhpc_pkg::cell_t      cin,
  output rhpc_pkg::cell_t      cout
);

  rhpc_pkg::cell_t          c_r;
  rhpc_pkg::cell_t          c_nxt;
  logic [rhpc_pkg::HD_W:0]  hr2;
  logic [rhpc_pkg::HD_W:0]  hdiff;
  logic                     hge;
  logic [rhpc_pkg::SD_W:0]  sr2;
  logic [rhpc_pkg::SD_W:0]  sdiff;
  logic                     sge;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    c_nxt = cin;
    hr2   = {cin.hrem, cin.hbits[rhpc_pkg::CELLS-1]};
    hdiff = hr2 - {1'b0, cin.hden};
    hge   = (hr2 >= {1'b0, cin.hden});
    sr2   = {cin.srem, cin.sbits[rhpc_pkg::CELLS-1]};
    sdiff = sr2 - {1'b0, cin.sden};
    sge   = (sr2 >= {1'b0, cin.sden});
    c_nxt.hrem  = hge ? hdiff[rhpc_pkg::HD_W-1:0] : hr2[rhpc_pkg::HD_W-1:0];
    c_nxt.hq    = {cin.hq[rhpc_pkg::CELLS-2:0], hge};
    c_nxt.hbits = {cin.hbits[rhpc_pkg::CELLS-2:0], 1'b0};
    c_nxt.srem  = sge ? sdiff[rhpc_pkg::SD_W-1:0] : sr2[rhpc_pkg::SD_W-1:0];
    c_nxt.sq    = {cin.sq[rhpc_pkg::CELLS-2:0], sge};
    c_nxt.sbits = {cin.sbits[rhpc_pkg::CELLS-2:0], 1'b0};
  end

  // valid bit is reset, payload just follows the enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else if (en) begin
      c_r.valid <= c_nxt.valid;
    end
    if (en) begin
      c_r.hrem  <= c_nxt.hrem;
      c_r.hden  <= c_nxt.hden;
      c_r.hbits <= c_nxt.hbits;
      c_r.hq    <= c_nxt.hq;
      c_r.srem  <= c_nxt.srem;
      c_r.sden  <= c_nxt.sden;
      c_r.sbits <= c_nxt.sbits;
      c_r.sq    <= c_nxt.sq;
      c_r.steep <= c_nxt.steep;
      c_r.xneg  <= c_nxt.xneg;
      c_r.yneg  <= c_nxt.yneg;
      c_r.grey  <= c_nxt.grey;
      c_r.inten <= c_nxt.inten;
    end
  end

  assign cout = c_r;

endmodule
`default_nettype wire

@@ rtl/rhpc_front.sv @@
`default_nettype none
// Entry stage: intensity, vector setup for hue, dividend/divisor setup
module rhpc_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              en,
  input  wire              valid,
  input  wire  [7:0]       red,
  input  wire  [7:0]       green,
  input  wire  [7:0]       blue,
  output rhpc_pkg::cell_t  cout
);

  localparam int NX_W = rhpc_pkg::SNUM_W + rhpc_pkg::CELLS;

  rhpc_pkg::cell_t              c_r;
  rhpc_pkg::cell_t              c_nxt;
  logic [9:0]                   sum;
  logic [7:0]                   mn;
  logic [10:0]                  ix;
  logic [24:0]                  iprod;
  logic signed [10:0]           xv;
  logic signed [8:0]            yv;
  logic [8:0]                   ax;
  logic [7:0]                   ay;
  logic [rhpc_pkg::HD_W-1:0]    xs;
  logic [rhpc_pkg::HD_W-1:0]    ys;
  logic [rhpc_pkg::HD_W-1:0]    lo;
  logic [rhpc_pkg::HD_W-1:0]    hi;
  logic                         steep;
  logic [9:0]                   dsat;
  logic [rhpc_pkg::SNUM_W-1:0]  snum;
  logic [NX_W-1:0]              snum_x;

  always_comb begin
    sum = {2'b00, red} + {2'b00, green} + {2'b00, blue};
    mn  = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;

    // round(sum/3) = floor((2*sum+3)/6), reciprocal multiply
    ix    = {sum, 1'b0} + 11'd3;
    iprod = ix * rhpc_pkg::RECIP6_Q16;

    // hue vector (|2R-G-B|, sqrt3*|G-B|)
    xv = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green}) - $signed({3'b000, blue});
    yv = $signed({1'b0, green}) - $signed({1'b0, blue});
    ax = xv[10] ? 9'(-xv) : xv[8:0];
    ay = yv[8] ? 8'(-yv) : yv[7:0];
    xs = {ax, 20'd0};
    ys = ay * rhpc_pkg::SQRT3_Q20;
    steep = (ys > xs);
    lo = steep ? xs : ys;
    hi = steep ? ys : xs;

    // saturation dividend
    dsat   = sum - (10'(mn) * 10'd3);
    snum   = (19'(dsat) * 19'd510) + 19'(sum);
    snum_x = NX_W'(snum);

    c_nxt.valid = valid;
    c_nxt.hrem  = {1'b0, lo[rhpc_pkg::HD_W-1:1]};
    c_nxt.hden  = hi;
    c_nxt.hbits = {lo[0], {(rhpc_pkg::CELLS-1){1'b0}}};
    c_nxt.hq    = '0;
    c_nxt.srem  = snum_x[rhpc_pkg::CELLS +: rhpc_pkg::SD_W];
    c_nxt.sden  = {sum, 1'b0};
    c_nxt.sbits = snum_x[rhpc_pkg::CELLS-1:0];
    c_nxt.sq    = '0;
    c_nxt.steep = steep;
    c_nxt.xneg  = xv[10];
    c_nxt.yneg  = yv[8];
    c_nxt.grey  = (red == green) && (green == blue);
    c_nxt.inten = iprod[23:16];
  end

  // valid bit is reset, payload just follows the enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else if (en) begin
      c_r.valid <= c_nxt.valid;
    end
    if (en) begin
      c_r.hrem  <= c_nxt.hrem;
      c_r.hden  <= c_nxt.hden;
      c_r.hbits <= c_nxt.hbits;
      c_r.hq    <= c_nxt.hq;
      c_r.srem  <= c_nxt.srem;
      c_r.sden  <= c_nxt.sden;
      c_r.sbits <= c_nxt.sbits;
      c_r.sq    <= c_nxt.sq;
      c_r.steep <= c_nxt.steep;
      c_r.xneg  <= c_nxt.xneg;
      c_r.yneg  <= c_nxt.yneg;
      c_r.grey  <= c_nxt.grey;
      c_r.inten <= c_nxt.inten;
    end
  end

  assign cout = c_r;

endmodule
`default_nettype wire

@@ rtl/rhpc_tail.sv @@
`default_nettype none
// Arctangent approximation, octant unfolding and output scaling
module rhpc_tail (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              en,
  input  rhpc_pkg::cell_t  cin,
  output rhpc_pkg::res_t   res
);

  localparam int C  = rhpc_pkg::CELLS;
  localparam int F  = rhpc_pkg::FRAC_BITS;
  localparam int PW = rhpc_pkg::P_W;
  localparam logic [C-1:0] ONE = C'(1) << F;

  // stage 1 registers
  logic           v1_r;
  logic [C-1:0]   z1_r;
  logic [PW-1:0]  p1_r;
  logic [C-1:0]   sq1_r;
  logic           steep1_r, xneg1_r, yneg1_r, grey1_r;
  logic [7:0]     inten1_r;
  // stage 2 registers
  logic           v2_r;
  logic [C-1:0]   ang2_r;
  logic [C-1:0]   sq2_r;
  logic           grey2_r;
  logic [7:0]     inten2_r;

  logic [C-1:0]     omz;
  logic [2*C-1:0]   zprod;
  logic [PW+15:0]   pkf;
  logic [C-1:0]     pk;
  logic [C-1:0]     t;
  logic [C-1:0]     a0;
  logic [C-1:0]     a1;
  logic [C-1:0]     ang_nxt;
  logic [C+9:0]     hp;
  logic [9:0]       hv;

  // z*(1-z)
  always_comb begin
    omz   = ONE - cin.hq;
    zprod = cin.hq * omz;
  end

  // t = z/8 + k*z*(1-z), then unfold to the full turn
  always_comb begin
    pkf = p1_r * rhpc_pkg::ATAN_K_Q20;
    pk  = C'(pkf >> 20);
    t   = (z1_r >> 3) + pk;
    a0  = steep1_r ? ((ONE >> 2) - t) : t;
    a1  = xneg1_r ? ((ONE >> 1) - a0) : a0;
    ang_nxt = yneg1_r ? (ONE - a1) : a1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= cin.valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r     <= cin.hq;
      p1_r     <= zprod[F +: PW];
      sq1_r    <= cin.sq;
      steep1_r <= cin.steep;
      xneg1_r  <= cin.xneg;
      yneg1_r  <= cin.yneg;
      grey1_r  <= cin.grey;
      inten1_r <= cin.inten;
      ang2_r   <= ang_nxt;
      sq2_r    <= sq1_r;
      grey2_r  <= grey1_r;
      inten2_r <= inten1_r;
    end
  end

  // scale by 255 with half-up rounding, clamp
  always_comb begin
    hp = ((C+10)'(ang2_r) * (C+10)'(255)) + ((C+10)'(1) << (F-1));
    hv = hp[F +: 10];
    res.valid = v2_r;
    res.inten = inten2_r;
    if (grey2_r) begin
      res.hue = 8'd0;
      res.sat = 8'd0;
    end else begin
      res.hue = (hv > 10'd255) ? 8'd255 : hv[7:0];
      res.sat = (sq2_r > C'(255)) ? 8'd255 : sq2_r[7:0];
    end
  end

endmodule
`default_nettype wire

@@ bench/rhpc_tb_pkg.sv @@
package rhpc_tb_pkg;

  // Fraction bits used by the hue arithmetic in the bench's own predictor
  localparam int HUE_F = 16;
  localparam longint unsigned SQRT3_FX = 64'd1816187;
  localparam longint unsigned ATAN_FX  = 64'd45560;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] inten;
  } hsi_t;

endpackage

@@ bench/rhpc_tb_ifs.sv @@
// Channel interfaces come from the RTL (rhpc_px_if, rhpc_hsi_if); this file
// holds the bench's idle pattern codes used by the testbench top.
package rhpc_tb_mode_pkg;
  typedef enum logic [1:0] {
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_NONE
  } idle_mode_e;
endpackage

@@ bench/hsi_checker.sv @@
module hsi_checker
  import rhpc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rhpc_px_if          px,
  rhpc_hsi_if         hsi,
  output int          fail_count,
  output int          pending
);

  hsi_t hsi_expected_q[$];
  int   mismatch_cnt;

  // Full-turn hue angle (octants unfolded) in turns, Q0.HUE_F
  function automatic longint unsigned hue_angle(longint unsigned r, longint unsigned g,
                                                longint unsigned b);
    longint unsigned one, ax, ay, xs, ys, lo, hi, z, p, t, ang;
    longint          xv, yv;
    logic            steep;
    one = 64'd1 << HUE_F;
    xv = 2 * longint'(r) - longint'(g) - longint'(b);
    yv = longint'(g) - longint'(b);
    ax = (xv < 0) ? -xv : xv;
    ay = (yv < 0) ? -yv : yv;
    xs = ax << 20;
    ys = ay * SQRT3_FX;
    steep = ys > xs;
    lo = steep ? xs : ys;
    hi = steep ? ys : xs;
    if (hi == 0) return 0;
    z = (lo << HUE_F) / hi;
    if (z > one) z = one;
    p = (z * (one - z)) >> HUE_F;
    t = (z >> 3) + ((p * ATAN_FX) >> 20);
    ang = steep ? ((one >> 2) - t) : t;
    if (xv < 0) ang = (one >> 1) - ang;
    if (yv < 0) ang = one - ang;
    return ang;
  endfunction

  function automatic hsi_t convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    longint unsigned r, g, b, sum, mn, h, s;
    hsi_t res;
    r = r8; g = g8; b = b8;
    sum = r + g + b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    h = 0;
    s = 0;
    if (!(r == g && g == b)) begin
      h = (hue_angle(r, g, b) * 255 + (64'd1 << (HUE_F - 1))) >> HUE_F;
      if (h > 255) h = 255;
      s = (510 * (sum - 3 * mn) + sum) / (2 * sum);
      if (s > 255) s = 255;
    end
    res.hue = h[7:0];
    res.sat = s[7:0];
    res.inten = 8'((2 * sum + 3) / 6);
    return res;
  endfunction

  assign pending = hsi_expected_q.size();

  // Predict on each input beat, compare on each output beat
  always @(posedge clk) begin
    hsi_t got, want;
    if (!rst_n) begin
      fail_count <= 0;
      mismatch_cnt = 0;
    end else begin
      if (hsi.valid && hsi.ready) begin
        got = '{hsi.hue, hsi.saturation, hsi.intensity};
        if (hsi_expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (mismatch_cnt < 10)
            $display("unexpected output beat: h=%0d s=%0d i=%0d", got.hue, got.sat, got.inten);
          mismatch_cnt++;
        end else begin
          want = hsi_expected_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (mismatch_cnt < 10)
              $display("mismatch: expected h=%0d s=%0d i=%0d, got h=%0d s=%0d i=%0d",
                       want.hue, want.sat, want.inten, got.hue, got.sat, got.inten);
            mismatch_cnt++;
          end
        end
      end
      if (px.valid && px.ready)
        hsi_expected_q.push_back(convert_pixel(px.red, px.green, px.blue));
    end
  end

endmodule

@@ bench/testbench.sv @@
module testbench;
  import rhpc_tb_mode_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  idle_mode_e idle_mode = IDLE_SENDER;

  rhpc_px_if  px ();
  rhpc_hsi_if hsi ();

  rgb_to_hsi_pixel_converter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (px),
    .out_hsi(hsi)
  );

  hsi_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .px        (px),
    .hsi       (hsi),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    px.valid = 1'b0;
    px.red = 8'd0;
    px.green = 8'd0;
    px.blue = 8'd0;
    hsi.ready = 1'b0;
  end

  // Receiver stalls per the current phase
  always @(negedge clk) begin
    if (idle_mode == IDLE_SENDER) hsi.ready <= ($urandom_range(99) >= 52);
    else if (idle_mode == IDLE_RECEIVER) hsi.ready <= ($urandom_range(99) >= 6);
    else hsi.ready <= 1'b1;
  end

  // Send one pixel beat; valid stays high across back-to-back beats
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 6 : (idle_mode == IDLE_RECEIVER) ? 52 : 0;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      px.valid <= 1'b0;
      @(negedge clk);
    end
    px.valid <= 1'b1;
    px.red <= r;
    px.green <= g;
    px.blue <= b;
    @(posedge clk);
    while (!px.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Directed corners, then random pixels over the three idle phases
  initial begin
    logic [7:0] r, g, b;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd10, 8'd10);
    send_pixel(8'd10, 8'd200, 8'd200);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd1);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd254);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd0, 8'd85, 8'd170);

    for (int ph = 0; ph < 3; ph++) begin
      idle_mode = idle_mode_e'(ph);
      for (int n = 0; n < 670; n++) begin
        r = pick_channel();
        g = pick_channel();
        b = pick_channel();
        // Some grey and green-equals-blue pixels
        if ($urandom_range(15) == 0) begin
          g = r;
          b = r;
        end else if ($urandom_range(15) == 0) begin
          b = g;
        end
        send_pixel(r, g, b);
      end
    end
    px.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ rgb_to_hsi_pixel_converter_top.f @@
+incdir+rtl
rtl/rhpc_pkg.sv
rtl/rhpc_px_if.sv
rtl/rhpc_hsi_if.sv
rtl/rhpc_cell.sv
rtl/rhpc_front.sv
rtl/rhpc_tail.sv
rtl/rgb_to_hsi_pixel_converter_top.sv
bench/rhpc_tb_pkg.sv
bench/rhpc_tb_ifs.sv
bench/hsi_checker.sv
bench/testbench.sv
